@@ design/spq_pkg.sv @@
// Package with the types and constants of the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int ID_BITS      = 16;
  localparam int URGENCY_BITS = 8;
  localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                    valid;
    logic [ID_BITS-1:0]      id;
    logic [URGENCY_BITS-1:0] urgency;
  } entry_t;

  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic [ID_BITS-1:0]      id;
    logic [URGENCY_BITS-1:0] urgency;
  } cell_cmd_t;

endpackage

@@ design/spq_cell.sv @@
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  entry_t    left_i,
  input  logic      left_gt_i,
  input  entry_t    right_i,
  output entry_t    entry_o,
  output logic      gt_o
);

  logic                    valid_q;
  logic [ID_BITS-1:0]      id_q;
  logic [URGENCY_BITS-1:0] urgency_q;
  entry_t                  entry_d;

  // A slot yields its place when it is empty or holds a strictly less urgent entry.
  assign gt_o          = !valid_q || (urgency_q > cmd_i.urgency);
  assign entry_o.valid   = valid_q;
  assign entry_o.id      = id_q;
  assign entry_o.urgency = urgency_q;

  always_comb begin
    entry_d = entry_o;
    if (cmd_i.enq && gt_o) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else begin
        entry_d.valid   = 1'b1;
        entry_d.id      = cmd_i.id;
        entry_d.urgency = cmd_i.urgency;
      end
    end else if (cmd_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q      <= entry_d.id;
    urgency_q <= entry_d.urgency;
  end

endmodule

@@ design/stable_priority_queue.sv @@
// A result is offered in the cycle after its operation is transferred.
// Throughput: one enqueue or dequeue per cycle while the result is taken, since every
// slot cell updates from its neighbors at once and an output register holds the result.
// Reset empties the queue: all slot valid bits and the entry count are cleared.
// Slot contents are not reset and are only read once written.
`timescale 1ns / 1ps

module stable_priority_queue
  import spq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    opcode_i,
  input  logic [ID_BITS-1:0]      task_id_i,
  input  logic [URGENCY_BITS-1:0] urgency_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [ID_BITS-1:0]      head_id_o,
  output logic [URGENCY_BITS-1:0] head_urgency_o,
  output logic [COUNT_BITS-1:0]   occupancy_o
);

  localparam logic [COUNT_BITS-1:0] FullCount = COUNT_BITS'(QUEUE_DEPTH);

  entry_t                    entries [QUEUE_DEPTH];
  logic   [QUEUE_DEPTH-1:0]  gts;
  logic   [QUEUE_DEPTH-1:0]  valid_vec;
  cell_cmd_t                 cmd;
  entry_t                    empty_entry;

  logic                      in_fire;
  logic                      is_full;
  logic                      is_empty;
  logic [COUNT_BITS-1:0]     count_q, count_d;
  logic                      out_valid_q;
  status_e                   status_q, status_d;
  logic [ID_BITS-1:0]        head_id_q, head_id_d;
  logic [URGENCY_BITS-1:0]   head_urg_q, head_urg_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == FullCount);
  assign is_empty   = (count_q == '0);

  assign empty_entry = '0;

  assign cmd.enq     = in_fire && (opcode_e'(opcode_i) == OP_ENQUEUE) && !is_full;
  assign cmd.deq     = in_fire && (opcode_e'(opcode_i) == OP_DEQUEUE) && !is_empty;
  assign cmd.id      = task_id_i;
  assign cmd.urgency = urgency_i;

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_gt;

    if (gi == 0) begin : g_first
      assign left_ent = empty_entry;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = entries[gi-1];
      assign left_gt  = gts[gi-1];
    end

    if (gi == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = empty_entry;
    end else begin : g_inner
      assign right_ent = entries[gi+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_ent),
      .left_gt_i (left_gt),
      .right_i   (right_ent),
      .entry_o   (entries[gi]),
      .gt_o      (gts[gi])
    );

    assign valid_vec[gi] = entries[gi].valid;
  end

  always_comb begin
    count_d    = count_q;
    status_d   = ST_DONE;
    head_id_d  = '0;
    head_urg_d = '0;
    if (opcode_e'(opcode_i) == OP_ENQUEUE) begin
      if (is_full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d    = count_q - 1'b1;
        head_id_d  = entries[0].id;
        head_urg_d = entries[0].urgency;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q   <= status_d;
      head_id_q  <= head_id_d;
      head_urg_q <= head_urg_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign head_id_o      = head_id_q;
  assign head_urgency_o = head_urg_q;
  assign occupancy_o    = count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("Entry count exceeds the queue depth.");

  a_valid_matches_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("Slot valid bits disagree with the entry count.");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entries[0].valid && entries[1].valid) |-> (entries[0].urgency <= entries[1].urgency))
    else $error("The head slot is less urgent than its neighbor.");

  a_enq_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.enq |=> (count_q == $past(count_q) + 1'b1))
    else $error("An accepted enqueue did not add one entry.");

  a_deq_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.deq |=> (count_q == $past(count_q) - 1'b1))
    else $error("An accepted dequeue did not remove one entry.");

endmodule

@@ tb/sv/stable_priority_queue_test.sv @@
// Testbench for the stable min-first priority queue with a self-checking queue model.
`timescale 1ns / 1ps

module stable_priority_queue_test;
  import spq_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    opcode_e                 op;
    logic [ID_BITS-1:0]      id;
    logic [URGENCY_BITS-1:0] urgency;
    int                      gap_after;
    bit                      wait_for_empty;
  } queue_op_t;

  typedef struct {
    logic [ID_BITS-1:0]      id;
    logic [URGENCY_BITS-1:0] urgency;
  } held_entry_t;

  typedef struct {
    status_e                 status;
    logic [ID_BITS-1:0]      id;
    logic [URGENCY_BITS-1:0] urgency;
    logic [COUNT_BITS-1:0]   occupancy;
  } queue_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    opcode_i = OP_ENQUEUE;
  logic [ID_BITS-1:0]      task_id_i = '0;
  logic [URGENCY_BITS-1:0] urgency_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [1:0]              status_o;
  logic [ID_BITS-1:0]      head_id_o;
  logic [URGENCY_BITS-1:0] head_urgency_o;
  logic [COUNT_BITS-1:0]   occupancy_o;

  queue_op_t     queued_ops[$];
  held_entry_t   held_entries[$];
  queue_result_t expected_results[$];
  int            results_in_flight = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            idle_cycles = 0;
  int            cycle_no = 0;
  int            error_count = 0;

  stable_priority_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .task_id_i      (task_id_i),
    .urgency_i      (urgency_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .head_id_o      (head_id_o),
    .head_urgency_o (head_urgency_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [URGENCY_BITS-1:0] pick_urgency();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return URGENCY_BITS'($urandom_range(0, 3));
    if (r == 3) return $urandom_range(0, 1) ? '1 : '0;
    return URGENCY_BITS'($urandom);
  endfunction

  task automatic add_op(opcode_e op, logic [ID_BITS-1:0] id,
                        logic [URGENCY_BITS-1:0] urgency, bit wait_for_empty);
    queue_op_t item;
    item.op = op;
    item.id = id;
    item.urgency = urgency;
    item.wait_for_empty = wait_for_empty;
    // Every hundred operations a stretch of twenty goes back to back.
    item.gap_after = (queued_ops.size() % 100 < 20) ? 0 : pick_gap();
    queued_ops.push_back(item);
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic queue_result_t predict_op(opcode_e op, logic [ID_BITS-1:0] id,
                                               logic [URGENCY_BITS-1:0] urgency);
    queue_result_t res;
    held_entry_t   entry;
    int            pos;
    res.status = ST_DONE;
    res.id = '0;
    res.urgency = '0;
    if (op == OP_ENQUEUE) begin
      if (held_entries.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // The new entry goes behind every entry of equal or smaller urgency.
        pos = held_entries.size();
        for (int i = 0; i < held_entries.size(); i++) begin
          if (held_entries[i].urgency > urgency) begin
            pos = i;
            break;
          end
        end
        entry.id = id;
        entry.urgency = urgency;
        held_entries.insert(pos, entry);
      end
    end else begin
      if (held_entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        entry = held_entries.pop_front();
        res.id = entry.id;
        res.urgency = entry.urgency;
      end
    end
    res.occupancy = COUNT_BITS'(held_entries.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver
    queue_op_t item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      opcode_i <= OP_ENQUEUE;
      task_id_i <= '0;
      urgency_i <= '0;
      send_gap <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (queued_ops.size() != 0 && (!queued_ops[0].wait_for_empty ||
                   (!in_valid_i && results_in_flight == 0))) begin
        item = queued_ops.pop_front();
        in_valid_i <= 1'b1;
        opcode_i <= item.op;
        task_id_i <= item.id;
        urgency_i <= item.urgency;
        send_gap <= item.gap_after;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
      cycle_no <= 0;
    end else begin
      cycle_no <= cycle_no + 1;
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (cycle_no % 1024 >= 256 && $urandom_range(0, 3) == 0) begin
          stall_left <= pick_gap();
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    queue_result_t exp_res;
    if (!rst_ni) begin
      results_in_flight <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no operation outstanding");
        end else begin
          exp_res = expected_results.pop_front();
          if (status_o !== exp_res.status)
            report_mismatch($sformatf("status got %0d expected %0d", status_o,
                                      exp_res.status));
          if (head_id_o !== exp_res.id)
            report_mismatch($sformatf("head_id got %h expected %h", head_id_o,
                                      exp_res.id));
          if (head_urgency_o !== exp_res.urgency)
            report_mismatch($sformatf("head_urgency got %0d expected %0d",
                                      head_urgency_o, exp_res.urgency));
          if (occupancy_o !== exp_res.occupancy)
            report_mismatch($sformatf("occupancy got %0d expected %0d", occupancy_o,
                                      exp_res.occupancy));
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_op(opcode_e'(opcode_i), task_id_i,
                                              urgency_i));
      end
      results_in_flight <= expected_results.size();
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("stable_priority_queue_test: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int enq_pct;
    // Dequeue from an empty queue, then fill it with extremes, ties and zero urgency.
    add_op(OP_DEQUEUE, '1, '1, 1'b0);
    add_op(OP_ENQUEUE, 16'h0000, 8'd255, 1'b0);
    add_op(OP_ENQUEUE, 16'hFFFF, 8'd0, 1'b0);
    add_op(OP_ENQUEUE, 16'h1234, 8'd1, 1'b0);
    for (int i = 0; i < 4; i++) add_op(OP_ENQUEUE, 16'(16'hA001 + i), 8'd7, 1'b0);
    add_op(OP_ENQUEUE, 16'h5555, 8'd128, 1'b0);
    add_op(OP_ENQUEUE, 16'hAAAA, 8'd254, 1'b0);
    add_op(OP_ENQUEUE, 16'h0F0F, 8'd3, 1'b0);
    add_op(OP_ENQUEUE, 16'hF0F0, 8'd7, 1'b0);
    add_op(OP_ENQUEUE, 16'h0001, 8'd0, 1'b0);
    add_op(OP_ENQUEUE, 16'h8000, 8'd255, 1'b0);
    add_op(OP_ENQUEUE, 16'h00FF, 8'd100, 1'b0);
    add_op(OP_ENQUEUE, 16'hFF00, 8'd50, 1'b0);
    add_op(OP_ENQUEUE, 16'h7FFF, 8'd2, 1'b0);
    // The queue is full now, so this enqueue must be refused.
    add_op(OP_ENQUEUE, 16'hBEEF, 8'd0, 1'b0);
    for (int i = 0; i < 3; i++) add_op(OP_DEQUEUE, 16'($urandom), 8'($urandom), 1'b0);
    // Random blocks lean toward enqueue or dequeue so the queue swings between empty and full.
    for (int blk = 0; blk < 12; blk++) begin
      case ($urandom_range(0, 4))
        0: enq_pct = 10;
        1: enq_pct = 25;
        2: enq_pct = 50;
        3: enq_pct = 75;
        default: enq_pct = 90;
      endcase
      for (int k = 0; k < 40; k++) begin
        add_op(($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
               16'($urandom), pick_urgency(), (blk == 0 || blk == 6) && k == 0);
      end
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (queued_ops.size() != 0 || in_valid_i || results_in_flight != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (error_count == 0) begin
      $display("stable_priority_queue_test: done, clean");
    end else begin
      $display("stable_priority_queue_test: done, errors");
    end
    $finish;
  end

endmodule
